[hdl/qxmm_pkg.sv]
// Shared constants and control types for the quad-X motor mixer.
package qxmm_pkg;

  localparam int FracBitsDef = 14;
  localparam int CmdW        = 16;
  localparam int MotorW      = 15;
  localparam int ShiftW      = 17;
  localparam int CfgW        = 15;
  localparam int NumMotors   = 4;

  typedef struct packed {
    logic valid;
    logic above_idle;
  } ctl_t;

  typedef struct packed {
    logic over;
    logic under;
  } sat_t;

endpackage

[hdl/qxmm_clamp.sv]
// Stage 1: saturate the four commands and compare throttle against idle.
module qxmm_clamp #(
  parameter int FRAC_BITS = qxmm_pkg::FracBitsDef,
  parameter int SW        = FRAC_BITS + 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qxmm_pkg::CmdW-1:0]     throttle_i,
  input  logic [qxmm_pkg::CmdW-1:0]     roll_i,
  input  logic [qxmm_pkg::CmdW-1:0]     pitch_i,
  input  logic [qxmm_pkg::CmdW-1:0]     yaw_i,
  input  logic [qxmm_pkg::CfgW-1:0]     idle_i,
  output qxmm_pkg::ctl_t                ctl_o,
  output logic signed [SW-1:0]          t_o,
  output logic signed [SW-1:0]          r_o,
  output logic signed [SW-1:0]          p_o,
  output logic signed [SW-1:0]          y_o
);
  import qxmm_pkg::*;

  localparam logic signed [SW-1:0] One = SW'(64'sd1 <<< FRAC_BITS);

  function automatic logic signed [SW-1:0] sext(input logic [CmdW-1:0] v);
    sext = {{(SW-CmdW){v[CmdW-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v,
                                               input logic signed [SW-1:0] lo);
    logic signed [SW-1:0] res;
    res = v;
    if (v < lo) res = lo;
    else if (v > One) res = One;
    sat = res;
  endfunction

  logic signed [SW-1:0] t_d;
  ctl_t                 ctl_d, ctl_q;
  logic signed [SW-1:0] t_q, r_q, p_q, y_q;

  always_comb begin
    t_d              = sat(sext(throttle_i), '0);
    ctl_d.valid      = valid_i;
    ctl_d.above_idle = t_d > $signed({{(SW-CfgW){1'b0}}, idle_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
      r_q <= sat(sext(roll_i), -One);
      p_q <= sat(sext(pitch_i), -One);
      y_q <= sat(sext(yaw_i), -One);
    end
  end

  assign ctl_o = ctl_q;
  assign t_o   = t_q;
  assign r_o   = r_q;
  assign p_o   = p_q;
  assign y_o   = y_q;

endmodule

[hdl/qxmm_mix.sv]
// Stages 2 and 3: quad-X sums, then max, min and saturation flags.
module qxmm_mix #(
  parameter int FRAC_BITS = qxmm_pkg::FracBitsDef,
  parameter int SW        = FRAC_BITS + 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  qxmm_pkg::ctl_t        ctl_i,
  input  logic signed [SW-1:0]  t_i,
  input  logic signed [SW-1:0]  r_i,
  input  logic signed [SW-1:0]  p_i,
  input  logic signed [SW-1:0]  y_i,
  output qxmm_pkg::ctl_t        ctl_o,
  output qxmm_pkg::sat_t        sat_o,
  output logic signed [SW-1:0]  m_o [qxmm_pkg::NumMotors],
  output logic signed [SW-1:0]  hi_o,
  output logic signed [SW-1:0]  lo_o
);
  import qxmm_pkg::*;

  localparam logic signed [SW-1:0] One = SW'(64'sd1 <<< FRAC_BITS);

  ctl_t                 ctl2_q, ctl3_q;
  logic signed [SW-1:0] m2_q [NumMotors];
  logic signed [SW-1:0] m3_q [NumMotors];
  logic signed [SW-1:0] hi_a, hi_b, lo_a, lo_b, hi_d, lo_d, hi_q, lo_q;
  sat_t                 sat_d, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m2_q[0] <= t_i - r_i + p_i - y_i;
      m2_q[1] <= t_i - r_i - p_i + y_i;
      m2_q[2] <= t_i + r_i + p_i + y_i;
      m2_q[3] <= t_i + r_i - p_i - y_i;
    end
  end

  always_comb begin
    hi_a = (m2_q[1] > m2_q[0]) ? m2_q[1] : m2_q[0];
    hi_b = (m2_q[3] > m2_q[2]) ? m2_q[3] : m2_q[2];
    lo_a = (m2_q[1] < m2_q[0]) ? m2_q[1] : m2_q[0];
    lo_b = (m2_q[3] < m2_q[2]) ? m2_q[3] : m2_q[2];
    hi_d = (hi_b > hi_a) ? hi_b : hi_a;
    lo_d = (lo_b < lo_a) ? lo_b : lo_a;
    sat_d.over  = hi_d > One;
    sat_d.under = lo_d < 0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q  <= m2_q;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      sat_q <= sat_d;
    end
  end

  assign ctl_o = ctl3_q;
  assign sat_o = sat_q;
  assign m_o   = m3_q;
  assign hi_o  = hi_q;
  assign lo_o  = lo_q;

endmodule

[hdl/qxmm_desat.sv]
// Stages 4 and 5: desaturation shift, then per-motor clamp into the output register.
module qxmm_desat #(
  parameter int FRAC_BITS = qxmm_pkg::FracBitsDef,
  parameter int SW        = FRAC_BITS + 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  qxmm_pkg::ctl_t                 ctl_i,
  input  qxmm_pkg::sat_t                 sat_i,
  input  logic signed [SW-1:0]           m_i [qxmm_pkg::NumMotors],
  input  logic signed [SW-1:0]           hi_i,
  input  logic signed [SW-1:0]           lo_i,
  output logic                           valid_o,
  output qxmm_pkg::sat_t                 sat_o,
  output logic [qxmm_pkg::MotorW-1:0]    motor_o [qxmm_pkg::NumMotors],
  output logic [qxmm_pkg::ShiftW-1:0]    shift_o
);
  import qxmm_pkg::*;

  localparam logic signed [SW-1:0] One = SW'(64'sd1 <<< FRAC_BITS);

  logic                 valid4_q, valid5_q;
  sat_t                 sat4_q, sat5_q;
  logic signed [SW-1:0] m4_q [NumMotors];
  logic signed [SW-1:0] down, shift_d, shift4_q;
  logic signed [SW-1:0] sum [NumMotors];
  logic [MotorW-1:0]    motor_d [NumMotors];
  logic [MotorW-1:0]    motor_q [NumMotors];
  logic [ShiftW-1:0]    shift5_q;

  always_comb begin
    down    = (hi_i > One) ? One - hi_i : '0;
    shift_d = (lo_i + down < 0) ? -lo_i : down;
    if (!ctl_i.above_idle) shift_d = '0;
  end

  always_comb begin
    for (int i = 0; i < NumMotors; i++) begin
      sum[i] = m4_q[i] + shift4_q;
      if (sum[i] < 0) motor_d[i] = '0;
      else if (sum[i] > One) motor_d[i] = One[MotorW-1:0];
      else motor_d[i] = sum[i][MotorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else if (en_i) begin
      valid4_q <= ctl_i.valid;
      valid5_q <= valid4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m4_q     <= m_i;
      sat4_q   <= sat_i;
      shift4_q <= shift_d;
      motor_q  <= motor_d;
      sat5_q   <= sat4_q;
      shift5_q <= shift4_q[ShiftW-1:0];
    end
  end

  assign valid_o = valid5_q;
  assign sat_o   = sat5_q;
  assign motor_o = motor_q;
  assign shift_o = shift5_q;

endmodule

[hdl/quad_x_motor_mixer.sv]
// Top level of the quad-X motor mixer with desaturation.
//
//   channel  direction  handshake                payload
//   in       request    in_valid_i / in_stall_o  throttle, roll, pitch, yaw commands
//   out      result     out_valid_o / out_stall_i motors 1..4, over/under flags, shift
//   cfg      write      cfg_we_i                 cfg_data_i = idle throttle
//
// Five register stages: clamp, sums, max/min, shift, motor clamp. One request
// is taken every cycle unless a stalled result holds the pipeline.
// Reset clears the stage valid bits and sets the idle throttle to zero.
// A stalled result holds the whole pipeline; in_stall_o follows out_stall_i
// while a result is waiting, so nothing is dropped or repeated.
module quad_x_motor_mixer #(
  parameter int FRAC_BITS = qxmm_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qxmm_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [qxmm_pkg::CmdW-1:0]     throttle_cmd_i,
  input  logic [qxmm_pkg::CmdW-1:0]     roll_cmd_i,
  input  logic [qxmm_pkg::CmdW-1:0]     pitch_cmd_i,
  input  logic [qxmm_pkg::CmdW-1:0]     yaw_cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [qxmm_pkg::MotorW-1:0]   motor_one_o,
  output logic [qxmm_pkg::MotorW-1:0]   motor_two_o,
  output logic [qxmm_pkg::MotorW-1:0]   motor_three_o,
  output logic [qxmm_pkg::MotorW-1:0]   motor_four_o,
  output logic                          over_flag_o,
  output logic                          under_flag_o,
  output logic [qxmm_pkg::ShiftW-1:0]   applied_shift_o
);
  import qxmm_pkg::*;

  localparam int SW = (FRAC_BITS + 5 > 18) ? FRAC_BITS + 5 : 18;

  logic [CfgW-1:0]      idle_q;
  logic                 en;
  ctl_t                 ctl1, ctl3;
  sat_t                 sat3, sat5;
  logic signed [SW-1:0] t1, r1, p1, y1, hi3, lo3;
  logic signed [SW-1:0] m3 [NumMotors];
  logic [MotorW-1:0]    motor [NumMotors];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= '0;
    end else if (cfg_we_i) begin
      idle_q <= cfg_data_i;
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  qxmm_clamp #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_clamp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .throttle_i (throttle_cmd_i),
    .roll_i     (roll_cmd_i),
    .pitch_i    (pitch_cmd_i),
    .yaw_i      (yaw_cmd_i),
    .idle_i     (idle_q),
    .ctl_o      (ctl1),
    .t_o        (t1),
    .r_o        (r1),
    .p_o        (p1),
    .y_o        (y1)
  );

  qxmm_mix #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl1),
    .t_i    (t1),
    .r_i    (r1),
    .p_i    (p1),
    .y_i    (y1),
    .ctl_o  (ctl3),
    .sat_o  (sat3),
    .m_o    (m3),
    .hi_o   (hi3),
    .lo_o   (lo3)
  );

  qxmm_desat #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_desat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl3),
    .sat_i   (sat3),
    .m_i     (m3),
    .hi_i    (hi3),
    .lo_i    (lo3),
    .valid_o (out_valid_o),
    .sat_o   (sat5),
    .motor_o (motor),
    .shift_o (applied_shift_o)
  );

  assign motor_one_o   = motor[0];
  assign motor_two_o   = motor[1];
  assign motor_three_o = motor[2];
  assign motor_four_o  = motor[3];
  assign over_flag_o   = sat5.over;
  assign under_flag_o  = sat5.under;

endmodule

[dv/tb_quad_x_motor_mixer.sv]
// Testbench for the quad-X motor mixer: directed, threshold sweep and random commands.
`timescale 1ns / 100ps

module tb_quad_x_motor_mixer;

  import qxmm_pkg::*;

  localparam int One = 1 << FracBitsDef;

  typedef struct packed {
    logic [NumMotors-1:0][MotorW-1:0] motor;
    logic                             over;
    logic                             under;
    logic [ShiftW-1:0]                shift;
  } mix_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CmdW-1:0]   throttle_cmd_i = '0;
  logic [CmdW-1:0]   roll_cmd_i = '0;
  logic [CmdW-1:0]   pitch_cmd_i = '0;
  logic [CmdW-1:0]   yaw_cmd_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [MotorW-1:0] motor_one_o;
  logic [MotorW-1:0] motor_two_o;
  logic [MotorW-1:0] motor_three_o;
  logic [MotorW-1:0] motor_four_o;
  logic              over_flag_o;
  logic              under_flag_o;
  logic [ShiftW-1:0] applied_shift_o;

  logic [CfgW-1:0] idle_thr = '0;
  mix_t            expected_mixes[$];
  int              idle_pct = 32;
  int              stall_pct = 32;
  int              mismatch_cnt = 0;
  int              request_cnt = 0;
  int              result_cnt = 0;
  int              over_cnt = 0;
  int              under_cnt = 0;
  int              shifted_cnt = 0;
  int              cfg_cnt = 0;

  quad_x_motor_mixer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .throttle_cmd_i  (throttle_cmd_i),
    .roll_cmd_i      (roll_cmd_i),
    .pitch_cmd_i     (pitch_cmd_i),
    .yaw_cmd_i       (yaw_cmd_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motor_one_o     (motor_one_o),
    .motor_two_o     (motor_two_o),
    .motor_three_o   (motor_three_o),
    .motor_four_o    (motor_four_o),
    .over_flag_o     (over_flag_o),
    .under_flag_o    (under_flag_o),
    .applied_shift_o (applied_shift_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int clamp_q(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic mix_t predict_mix(input logic [CmdW-1:0] thr, rol, pit, yw);
    mix_t res;
    int   t, r, p, y, hi, lo, sh;
    int   sum[NumMotors];
    t = clamp_q(int'($signed(thr)), 0, One);
    r = clamp_q(int'($signed(rol)), -One, One);
    p = clamp_q(int'($signed(pit)), -One, One);
    y = clamp_q(int'($signed(yw)), -One, One);
    sum[0] = t - r + p - y;
    sum[1] = t - r - p + y;
    sum[2] = t + r + p + y;
    sum[3] = t + r - p - y;
    res.over  = 1'b0;
    res.under = 1'b0;
    hi = sum[0];
    lo = sum[0];
    sh = 0;
    for (int i = 0; i < NumMotors; i++) begin
      if (sum[i] > One) res.over = 1'b1;
      if (sum[i] < 0) res.under = 1'b1;
      if (sum[i] > hi) hi = sum[i];
      if (sum[i] < lo) lo = sum[i];
    end
    if (t > int'(idle_thr)) begin
      if (hi > One) sh = One - hi;
      if (lo + sh < 0) sh = -lo;
    end
    for (int i = 0; i < NumMotors; i++) res.motor[i] = MotorW'(clamp_q(sum[i] + sh, 0, One));
    res.shift = ShiftW'(sh);
    return res;
  endfunction

  // result side: random stall, check every accepted result in order
  always @(posedge clk_i) begin
    mix_t exp_mix;
    mix_t got_mix;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_mix.motor[0] = motor_one_o;
      got_mix.motor[1] = motor_two_o;
      got_mix.motor[2] = motor_three_o;
      got_mix.motor[3] = motor_four_o;
      got_mix.over     = over_flag_o;
      got_mix.under    = under_flag_o;
      got_mix.shift    = applied_shift_o;
      result_cnt++;
      if (expected_mixes.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with no request pending: %p", $time, got_mix);
      end else begin
        exp_mix = expected_mixes.pop_front();
        for (int i = 0; i < NumMotors; i++)
          if (got_mix.motor[i] !== exp_mix.motor[i]) begin
            mismatch_cnt++;
            $display("%0t: motor %0d expected %0d actual %0d", $time, i + 1,
                     exp_mix.motor[i], got_mix.motor[i]);
          end
        if (got_mix.over !== exp_mix.over) begin
          mismatch_cnt++;
          $display("%0t: over_flag expected %0b actual %0b", $time, exp_mix.over, got_mix.over);
        end
        if (got_mix.under !== exp_mix.under) begin
          mismatch_cnt++;
          $display("%0t: under_flag expected %0b actual %0b", $time, exp_mix.under,
                   got_mix.under);
        end
        if (got_mix.shift !== exp_mix.shift) begin
          mismatch_cnt++;
          $display("%0t: applied_shift expected %0d actual %0d", $time,
                   $signed(exp_mix.shift), $signed(got_mix.shift));
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_cmd(input int thr, input int rol, input int pit, input int yw);
    mix_t exp_mix;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    throttle_cmd_i <= CmdW'(thr);
    roll_cmd_i     <= CmdW'(rol);
    pitch_cmd_i    <= CmdW'(pit);
    yaw_cmd_i      <= CmdW'(yw);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_mix = predict_mix(CmdW'(thr), CmdW'(rol), CmdW'(pit), CmdW'(yw));
    expected_mixes.push_back(exp_mix);
    request_cnt++;
    if (exp_mix.over) over_cnt++;
    if (exp_mix.under) under_cnt++;
    if (exp_mix.shift != '0) shifted_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_mixes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_idle(input int val);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= CfgW'(val);
    @(posedge clk_i);
    idle_thr = CfgW'(val);
    cfg_we_i <= 1'b0;
    cfg_cnt++;
  endtask

  function automatic int rand_cmd(input bit is_thr);
    case ($urandom_range(9))
      0: return int'($signed(16'($urandom)));
      1: case ($urandom_range(6))
           0: return -32768;
           1: return 32767;
           2: return One;
           3: return -One;
           4: return One + 1;
           5: return -One - 1;
           default: return 0;
         endcase
      default: return is_thr ? int'($urandom_range(One)) : int'($urandom_range(2 * One)) - One;
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(0, 0, 0, 0);
    send_cmd(0, 8000, -3000, 2000);
    send_cmd(-32768, -32768, -32768, -32768);
    send_cmd(32767, 32767, 32767, 32767);
    send_cmd(One, One, One, One);
    send_cmd(One, 0, 0, 0);
    send_cmd(One + 1, One + 1, -One - 1, 0);
    send_cmd(-1, 100, 100, 100);
    send_cmd(One, 8192, 0, 0);
    send_cmd(2000, 4000, 0, 0);
    send_cmd(1, One, One, One);
    send_cmd(1, -One, -One, -One);
    send_cmd(One, -One, One, -One);
    send_cmd(One, One, -One, -One);
    send_cmd(8192, 0, 0, 8192);
    send_cmd(21845, -21846, 21845, -21846);
    send_cmd(-21846, 21845, -21846, 21845);
    send_cmd(12000, 3000, 3000, 3000);
    send_cmd(4000, -1000, 2000, -3000);
    send_cmd(One - 1, 1, -1, 0);
    drain();
  endtask

  task automatic test_idle_sweep();
    int levels[6] = '{32767, One, 8192, 1, 21845, 0};
    foreach (levels[k]) begin
      write_idle(levels[k]);
      for (int n = 0; n < 18; n++)
        send_cmd(clamp_q(levels[k] + int'($urandom_range(4)) - 2, -2, 32767),
                 rand_cmd(0), rand_cmd(0), rand_cmd(0));
      drain();
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(3))
        0: write_idle(0);
        1: write_idle($urandom_range(One / 4));
        2: write_idle($urandom_range(One));
        default: write_idle($urandom_range(32767));
      endcase
      idle_pct  = (ph == 2) ? 0 : 32;
      stall_pct = (ph == 2) ? 0 : 32;
      for (int n = 0; n < 145; n++) send_cmd(rand_cmd(1), rand_cmd(0), rand_cmd(0), rand_cmd(0));
      drain();
    end
    idle_pct  = 32;
    stall_pct = 32;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idle_sweep();
    test_random();
    drain();
    $display("Ran %0d requests and checked %0d results over %0d idle throttle settings.",
             request_cnt, result_cnt, cfg_cnt);
    $display("Results with over: %0d, with under: %0d, with a nonzero shift: %0d.",
             over_cnt, under_cnt, shifted_cnt);
    if (mismatch_cnt == 0 && expected_mixes.size() == 0) begin
      $display("quad_x_motor_mixer test passed");
    end else begin
      $display("quad_x_motor_mixer test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results outstanding", expected_mixes.size());
    $display("quad_x_motor_mixer test failed");
    $finish;
  end

endmodule

[files.f]
hdl/qxmm_pkg.sv
hdl/qxmm_clamp.sv
hdl/qxmm_mix.sv
hdl/qxmm_desat.sv
hdl/quad_x_motor_mixer.sv
dv/tb_quad_x_motor_mixer.sv
